@@ rtl/srpg_pkg.sv @@
// Package for the stepper ramp pulse generator.
// Holds field widths, register indexes, reset values and the structs shared
// by the sequencer and the top level. No dependencies.
package srpg_pkg;

	localparam int RPM_W     = 12;
	localparam int SPR_W     = 10;
	localparam int PW_W      = 8;
	localparam int RAMP_W    = 10;
	localparam int SLOW_W    = 4;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	// Intervals in ticks; the slowest one is 15 * 60000000 < 2**30.
	localparam int INTV_W  = 30;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 12;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	// Divider: span * k stays below 2**40, rpm * steps_per_rev below 2**22.
	localparam int DVD_W   = 40;
	localparam int DVS_W   = 22;

	localparam int unsigned TICKS_PER_MIN = 60000000;

	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_SLOWDOWN = 2'd3;

	localparam logic [SPR_W-1:0]  RST_STEPS_PER_REV  = 10'd200;
	localparam logic [PW_W-1:0]   RST_PULSE_WIDTH    = 8'd5;
	localparam logic [RAMP_W-1:0] RST_RAMP_LIMIT     = 10'd100;
	localparam logic [SLOW_W-1:0] RST_START_SLOWDOWN = 4'd4;

	typedef struct packed {
		logic [SPR_W-1:0]  steps_per_rev;
		logic [PW_W-1:0]   pulse_width;
		logic [RAMP_W-1:0] ramp_limit;
		logic [SLOW_W-1:0] start_slowdown;
	} srpg_cfg_t;

	typedef struct packed {
		logic step_out;
		logic dir_out;
		logic enable_n;
		logic busy_res;
		logic done_res;
		logic start_ignored;
	} srpg_res_t;

endpackage

@@ rtl/stepper_ramp_pulse_generator.sv @@
// Top level of the stepper ramp pulse generator: register file, result word
// register and the sequencer srpg_seq (with its divider). Uses srpg_pkg.
//
//   port group   direction  handshake            payload
//   input word   in         in_valid / in_stall  mode, step_count, max_rpm
//   result word  out        out_valid/out_stall  step_out, dir_out, enable_n,
//                                                busy_res, done_res, start_ignored
//   registers    in         cfg_we               cfg_index, cfg_data
//
// A tick that does not begin a step goes straight to the response state. A tick
// that begins a ramp step first runs the span multiply and the divider, and a start
// word also works out the step intervals; the divider gives one quotient bit per cycle.
// One word is in flight at a time: in_stall is high from acceptance until
// the result word is loaded into the output register.
// Reset puts the registers at their defaults and the driver off.
module stepper_ramp_pulse_generator #(
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [srpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srpg_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic signed [STEP_COUNT_BITS-1:0]    step_count,
	input  logic [srpg_pkg::RPM_W-1:0]           max_rpm,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 step_out,
	output logic                                 dir_out,
	output logic                                 enable_n,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic                                 start_ignored
);
	import srpg_pkg::*;

	srpg_cfg_t cfg_q;
	srpg_res_t res;
	srpg_res_t res_q;
	logic      out_valid_q;
	logic      idle;
	logic      in_take;
	logic      res_ready;
	logic      res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_rev  <= RST_STEPS_PER_REV;
			cfg_q.pulse_width    <= RST_PULSE_WIDTH;
			cfg_q.ramp_limit     <= RST_RAMP_LIMIT;
			cfg_q.start_slowdown <= RST_START_SLOWDOWN;
		end else if (cfg_we) begin
			case (cfg_index)
			REG_STEPS_PER_REV:  cfg_q.steps_per_rev  <= cfg_data[SPR_W-1:0];
			REG_PULSE_WIDTH:    cfg_q.pulse_width    <= cfg_data[PW_W-1:0];
			REG_RAMP_LIMIT:     cfg_q.ramp_limit     <= cfg_data[RAMP_W-1:0];
			REG_START_SLOWDOWN: cfg_q.start_slowdown <= cfg_data[SLOW_W-1:0];
			default: begin
			end
			endcase
		end
	end

	assign in_stall  = !idle;
	assign in_take   = in_valid && idle;
	assign res_ready = !out_valid_q || !out_stall;

	srpg_seq #(
		.STEP_COUNT_BITS (STEP_COUNT_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_take    (in_take),
		.mode       (mode),
		.step_count (step_count),
		.max_rpm    (max_rpm),
		.res_ready  (res_ready),
		.idle       (idle),
		.res_load   (res_load),
		.res        (res)
	);

	// Result word register: load when free or being taken, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign step_out      = res_q.step_out;
	assign dir_out       = res_q.dir_out;
	assign enable_n      = res_q.enable_n;
	assign busy_res      = res_q.busy_res;
	assign done_res      = res_q.done_res;
	assign start_ignored = res_q.start_ignored;

endmodule

@@ rtl/srpg_div.sv @@
// Iterative restoring divider for the stepper ramp pulse generator.
// One quotient bit per cycle, DVD_W quotient bits per division. Uses srpg_pkg.
module srpg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [srpg_pkg::DVD_W-1:0] dividend,
	input  logic [srpg_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [srpg_pkg::DVD_W-1:0] quotient
);
	import srpg_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;

	// Bring down the next dividend bit and try the subtract.
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/srpg_seq.sv @@
// Sequencer and move state of the stepper ramp pulse generator.
// Drives one shared multiplier and the shared divider srpg_div to work out
// step intervals. Uses srpg_pkg.
module srpg_seq #(
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srpg_pkg::srpg_cfg_t               cfg,
	input  logic                              in_take,
	input  logic                              mode,
	input  logic signed [STEP_COUNT_BITS-1:0] step_count,
	input  logic [srpg_pkg::RPM_W-1:0]        max_rpm,
	input  logic                              res_ready,
	output logic                              idle,
	output logic                              res_load,
	output srpg_pkg::srpg_res_t               res
);
	import srpg_pkg::*;

	localparam int IDX_W  = STEP_COUNT_BITS;
	localparam int WIDE_W = ((IDX_W > RAMP_W) ? IDX_W : RAMP_W) + 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RPM_MUL  = 3'd1;
	localparam logic [2:0] ST_FAST_DIV = 3'd2;
	localparam logic [2:0] ST_SLOW_MUL = 3'd3;
	localparam logic [2:0] ST_STEP_SEL = 3'd4;
	localparam logic [2:0] ST_SPAN_MUL = 3'd5;
	localparam logic [2:0] ST_SPAN_DIV = 3'd6;
	localparam logic [2:0] ST_RESP     = 3'd7;

	logic [2:0]         state_q;
	logic               moving_q;
	logic               driver_off_q;
	logic               dir_q;
	logic               pulse_high_q;
	logic               done_q;
	logic               ign_q;
	logic               div_go_q;
	logic [IDX_W-1:0]   total_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RAMP_W-1:0]  ramp_q;
	logic [INTV_W-1:0]  fast_q;
	logic [INTV_W-1:0]  slow_q;
	logic [INTV_W-1:0]  cur_q;
	logic [INTV_W-1:0]  timer_q;
	logic [MUL_A_W-1:0] op_a_q;
	logic [MUL_B_W-1:0] op_b_q;
	logic [PROD_W-1:0]  prod_q;

	logic [IDX_W-1:0]   cnt_raw;
	logic               neg;
	logic [IDX_W-1:0]   mag;
	logic [WIDE_W-1:0]  half_w;
	logic [WIDE_W-1:0]  lim_w;
	logic [RAMP_W-1:0]  ramp_new;
	logic [RPM_W-1:0]   rpm_eff;
	logic [SPR_W-1:0]   spr_eff;
	logic [SLOW_W-1:0]  slow_eff;
	logic [PW_W-1:0]    pw_eff;
	logic [INTV_W-1:0]  pw_w;
	logic [INTV_W-1:0]  timer_dec;
	logic [INTV_W-1:0]  low_time;
	logic [IDX_W:0]     idx_inc;
	logic               step_last;
	logic [WIDE_W-1:0]  i_w;
	logic [WIDE_W-1:0]  r_w;
	logic [WIDE_W-1:0]  t_w;
	logic [WIDE_W-1:0]  tail_w;
	logic               in_accel;
	logic               in_decel;
	logic               use_ramp;
	logic [RAMP_W-1:0]  k_sel;
	logic [PROD_W-1:0]  mul_p;
	logic               div_done;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic [DVD_W-1:0]   div_quo;

	// Start word decode
	assign cnt_raw  = step_count;
	assign neg      = cnt_raw[IDX_W-1];
	assign mag      = neg ? (~cnt_raw + IDX_W'(1)) : cnt_raw;
	assign half_w   = WIDE_W'(mag >> 1);
	assign lim_w    = WIDE_W'(cfg.ramp_limit);
	assign ramp_new = (half_w < lim_w) ? half_w[RAMP_W-1:0] : cfg.ramp_limit;

	// Zero settings count as one
	assign rpm_eff  = (max_rpm == '0) ? RPM_W'(1) : max_rpm;
	assign spr_eff  = (cfg.steps_per_rev == '0) ? SPR_W'(1) : cfg.steps_per_rev;
	assign slow_eff = (cfg.start_slowdown == '0) ? SLOW_W'(1) : cfg.start_slowdown;
	assign pw_eff   = (cfg.pulse_width == '0) ? PW_W'(1) : cfg.pulse_width;
	assign pw_w     = INTV_W'(pw_eff);

	// Tick path
	assign timer_dec = timer_q - INTV_W'(1);
	assign low_time  = (cur_q > pw_w) ? (cur_q - pw_w) : INTV_W'(1);
	assign idx_inc   = {1'b0, idx_q} + (IDX_W + 1)'(1);
	assign step_last = idx_inc >= {1'b0, total_q};

	// Ramp position of the step about to start
	assign i_w      = WIDE_W'(idx_q);
	assign r_w      = WIDE_W'(ramp_q);
	assign t_w      = WIDE_W'(total_q);
	assign tail_w   = t_w - i_w - WIDE_W'(1);
	assign in_accel = i_w < r_w;
	assign in_decel = (i_w + r_w) >= t_w;
	assign use_ramp = (ramp_q != '0) && (in_accel || in_decel);
	assign k_sel    = in_accel ? i_w[RAMP_W-1:0] : tail_w[RAMP_W-1:0];

	// Shared multiplier
	assign mul_p = op_a_q * op_b_q;

	assign div_dvd = (state_q == ST_FAST_DIV) ? DVD_W'(TICKS_PER_MIN) : prod_q[DVD_W-1:0];
	assign div_dvs = (state_q == ST_FAST_DIV) ? prod_q[DVS_W-1:0] : DVS_W'(ramp_q);

	srpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			moving_q     <= 1'b0;
			driver_off_q <= 1'b1;
			dir_q        <= 1'b0;
			pulse_high_q <= 1'b0;
			done_q       <= 1'b0;
			ign_q        <= 1'b0;
			div_go_q     <= 1'b0;
			total_q      <= '0;
			idx_q        <= '0;
			ramp_q       <= '0;
			fast_q       <= '0;
			slow_q       <= '0;
			cur_q        <= '0;
			timer_q      <= '0;
			op_a_q       <= '0;
			op_b_q       <= '0;
			prod_q       <= '0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					done_q  <= 1'b0;
					ign_q   <= 1'b0;
					state_q <= ST_RESP;
					if (!mode) begin
						if (moving_q) begin
							ign_q <= 1'b1;
						end else begin
							dir_q   <= !neg && (cnt_raw != '0);
							total_q <= mag;
							idx_q   <= '0;
							ramp_q  <= ramp_new;
							if (mag == '0) begin
								done_q       <= 1'b1;
								pulse_high_q <= 1'b0;
								timer_q      <= '0;
								driver_off_q <= 1'b1;
							end else begin
								moving_q     <= 1'b1;
								driver_off_q <= 1'b0;
								op_a_q       <= MUL_A_W'(rpm_eff);
								op_b_q       <= MUL_B_W'(spr_eff);
								state_q      <= ST_RPM_MUL;
							end
						end
					end else if (moving_q) begin
						if (timer_dec != '0) begin
							timer_q <= timer_dec;
						end else if (pulse_high_q) begin
							pulse_high_q <= 1'b0;
							timer_q      <= low_time;
						end else begin
							idx_q   <= idx_inc[IDX_W-1:0];
							timer_q <= timer_dec;
							if (step_last) begin
								moving_q     <= 1'b0;
								driver_off_q <= 1'b1;
								done_q       <= 1'b1;
							end else begin
								state_q <= ST_STEP_SEL;
							end
						end
					end
				end
			end
			ST_RPM_MUL: begin
				prod_q   <= mul_p;
				div_go_q <= 1'b1;
				state_q  <= ST_FAST_DIV;
			end
			ST_FAST_DIV: begin
				if (div_done) begin
					fast_q  <= div_quo[INTV_W-1:0];
					op_a_q  <= MUL_A_W'(div_quo[INTV_W-1:0]);
					op_b_q  <= MUL_B_W'(slow_eff);
					state_q <= ST_SLOW_MUL;
				end
			end
			ST_SLOW_MUL: begin
				slow_q  <= mul_p[INTV_W-1:0];
				state_q <= ST_STEP_SEL;
			end
			ST_STEP_SEL: begin
				if (use_ramp) begin
					op_a_q  <= MUL_A_W'(slow_q - fast_q);
					op_b_q  <= MUL_B_W'(k_sel);
					state_q <= ST_SPAN_MUL;
				end else begin
					cur_q        <= fast_q;
					pulse_high_q <= 1'b1;
					timer_q      <= pw_w;
					state_q      <= ST_RESP;
				end
			end
			ST_SPAN_MUL: begin
				prod_q   <= mul_p;
				div_go_q <= 1'b1;
				state_q  <= ST_SPAN_DIV;
			end
			ST_SPAN_DIV: begin
				if (div_done) begin
					cur_q        <= slow_q - div_quo[INTV_W-1:0];
					pulse_high_q <= 1'b1;
					timer_q      <= pw_w;
					state_q      <= ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_ready) begin
					state_q <= ST_IDLE;
				end
			end
			default: begin
				state_q <= ST_IDLE;
			end
			endcase
		end
	end

	assign idle     = state_q == ST_IDLE;
	assign res_load = (state_q == ST_RESP) && res_ready;

	always_comb begin
		res.step_out      = pulse_high_q;
		res.dir_out       = dir_q;
		res.enable_n      = driver_off_q;
		res.busy_res      = moving_q;
		res.done_res      = done_q;
		res.start_ignored = ign_q;
	end

endmodule

@@ rtl/srpg_chk.sv @@
// Port checker for the stepper ramp pulse generator, bound to the top level.
// Sees the handshake and result ports only. No package dependencies.
module srpg_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic step_out,
	input logic dir_out,
	input logic enable_n,
	input logic busy_res,
	input logic done_res,
	input logic start_ignored
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step_out) && $stable(dir_out)
			&& $stable(enable_n) && $stable(busy_res) && $stable(done_res)
			&& $stable(start_ignored))
		else $error("stalled result word changed");

	// One word at a time: stall right after an accepted word
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input word accepted while another is in flight");

	// Driver is on exactly while a move runs
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (busy_res == !enable_n))
		else $error("driver enable disagrees with busy");

	// Step pulses only during a move; completion ends the move
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (step_out || done_res) |-> (step_out == busy_res) || done_res
			&& !busy_res && !step_out)
		else $error("step pulse or done outside a move");

	// A dropped start leaves the move running
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_ignored |-> busy_res && !done_res)
		else $error("start dropped while idle");

endmodule

bind stepper_ramp_pulse_generator srpg_chk u_srpg_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.step_out      (step_out),
	.dir_out       (dir_out),
	.enable_n      (enable_n),
	.busy_res      (busy_res),
	.done_res      (done_res),
	.start_ignored (start_ignored)
);
